>>> hdl/xfr_pkg.sv
// ----------------------------------------------------------------------------
// xfr_pkg
// Types and constants shared by the framed-byte receiver modules.
// ----------------------------------------------------------------------------
package xfr_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_HEADER_FIRST    = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND   = 2'd1;
	localparam logic [1:0] REG_KNOWN_MSG_ID    = 2'd2;
	localparam logic [1:0] REG_MAX_PAYLOAD_LEN = 2'd3;

	// Frame layout: two header bytes and the length byte come first
	localparam logic [7:0] IDX_HEADER_FIRST  = 8'd0;
	localparam logic [7:0] IDX_HEADER_SECOND = 8'd1;
	localparam logic [7:0] IDX_LENGTH        = 8'd2;
	localparam logic [7:0] IDX_MSG_ID        = 8'd3;
	localparam logic [7:0] IDX_ARG           = 8'd4;
	localparam logic [7:0] COUNT_MAX         = 8'hFF;
	localparam logic [8:0] CKSUM_OFFSET      = 9'd3;
	localparam logic [8:0] FRAME_OVERHEAD    = 9'd4;
	localparam logic [7:0] MIN_BYTES         = 8'd3;
	localparam logic [7:0] RESET_MAX_LEN     = 8'd64;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_HEADER    = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_TRUNCATED = 3'd4,
		ST_CHECKSUM  = 3'd5,
		ST_UNKNOWN   = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] known_msg_id;
		logic [7:0] max_payload_len;
	} cfg_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] msg_id;
		logic [7:0] arg_byte;
		logic [7:0] payload_len;
	} result_t;

endpackage

>>> hdl/xor_frame_receiver.sv
// ----------------------------------------------------------------------------
// xor_frame_receiver
// Checks framed serial bytes (header, length, payload, XOR checksum) and
// reports one status result per burst.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while in_stall is low; each byte updates
// the burst counters and running XOR; the byte flagged end_of_burst places a
// result in the output buffer on the next edge (on the outputs right away when
// the output register is free, else in the skid entry behind it). A two-entry
// output buffer lets bytes keep flowing while a result waits; in_stall rises
// only when both entries hold unread results. Configuration registers are
// written through the cfg channel, which is always ready, and should be
// changed only while no burst is in progress and no result is pending.
module xor_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       end_of_burst,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] msg_id,
	output logic [7:0] arg_byte,
	output logic [7:0] payload_len,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	xfr_pkg::cfg_t    cfg_q;
	xfr_pkg::result_t res;
	xfr_pkg::result_t out_data;
	logic             res_valid;
	logic             buf_full;
	logic             in_xfer;

	assign cfg_ready = 1'b1;
	assign in_stall  = buf_full;
	assign in_xfer   = in_valid & ~in_stall;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first    <= '0;
			cfg_q.header_second   <= '0;
			cfg_q.known_msg_id    <= '0;
			cfg_q.max_payload_len <= xfr_pkg::RESET_MAX_LEN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				xfr_pkg::REG_HEADER_FIRST:    cfg_q.header_first    <= cfg_data;
				xfr_pkg::REG_HEADER_SECOND:   cfg_q.header_second   <= cfg_data;
				xfr_pkg::REG_KNOWN_MSG_ID:    cfg_q.known_msg_id    <= cfg_data;
				xfr_pkg::REG_MAX_PAYLOAD_LEN: cfg_q.max_payload_len <= cfg_data;
				default: ;
			endcase
		end
	end

	xfr_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (in_xfer),
		.rx_byte      (rx_byte),
		.end_of_burst (end_of_burst),
		.cfg          (cfg_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	xfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign status      = out_data.status;
	assign msg_id      = out_data.msg_id;
	assign arg_byte    = out_data.arg_byte;
	assign payload_len = out_data.payload_len;

	// A last-byte transfer always leaves a result waiting
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && end_of_burst |=> out_valid)
		else $error("no result after end of burst");

	// Input only backs up when a result is pending
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// Reported status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 3'd7)
		else $error("undefined status code");

endmodule

>>> hdl/xfr_parser.sv
// ----------------------------------------------------------------------------
// xfr_parser
// Burst state registers; updates them on each byte and builds the status
// result on the last byte of a burst.
// ----------------------------------------------------------------------------
module xfr_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	input  logic [7:0]       rx_byte,
	input  logic             end_of_burst,
	input  xfr_pkg::cfg_t    cfg,
	output logic             res_valid,
	output xfr_pkg::result_t res
);

	logic [7:0] byte_count_q, byte_count_d;
	logic [1:0] header_ok_q, header_ok_d;
	logic [7:0] frame_len_q, frame_len_d;
	logic [7:0] running_xor_q, running_xor_d;
	logic [7:0] id_byte_q, id_byte_d;
	logic [7:0] second_byte_q, second_byte_d;
	logic       sum_matched_q, sum_matched_d;
	logic [8:0] ck_idx;
	logic [8:0] idx_ext;
	logic [8:0] need_cnt;

	assign ck_idx  = {1'b0, frame_len_q} + xfr_pkg::CKSUM_OFFSET;
	assign idx_ext = {1'b0, byte_count_q};

	// Advance the burst state by one byte
	always_comb begin
		byte_count_d  = byte_count_q;
		header_ok_d   = header_ok_q;
		frame_len_d   = frame_len_q;
		running_xor_d = running_xor_q;
		id_byte_d     = id_byte_q;
		second_byte_d = second_byte_q;
		sum_matched_d = sum_matched_q;
		if (byte_count_q != xfr_pkg::COUNT_MAX) begin
			if (byte_count_q == xfr_pkg::IDX_HEADER_FIRST) begin
				if (rx_byte == cfg.header_first) header_ok_d[0] = 1'b1;
			end else if (byte_count_q == xfr_pkg::IDX_HEADER_SECOND) begin
				if (rx_byte == cfg.header_second) header_ok_d[1] = 1'b1;
			end else if (byte_count_q == xfr_pkg::IDX_LENGTH) begin
				frame_len_d   = rx_byte;
				running_xor_d = rx_byte;
			end else begin
				if (byte_count_q == xfr_pkg::IDX_MSG_ID) id_byte_d = rx_byte;
				if (byte_count_q == xfr_pkg::IDX_ARG) second_byte_d = rx_byte;
				if (idx_ext < ck_idx) begin
					running_xor_d = running_xor_q ^ rx_byte;
				end else if (idx_ext == ck_idx) begin
					sum_matched_d = (rx_byte == running_xor_q);
				end
			end
			byte_count_d = byte_count_q + 8'd1;
		end
	end

	assign need_cnt = {1'b0, frame_len_d} + xfr_pkg::FRAME_OVERHEAD;

	// Check the finished frame in priority order
	always_comb begin
		priority if (byte_count_d < xfr_pkg::MIN_BYTES)       res.status = xfr_pkg::ST_SHORT;
		else if (header_ok_d != 2'b11)                        res.status = xfr_pkg::ST_HEADER;
		else if (frame_len_d > cfg.max_payload_len)           res.status = xfr_pkg::ST_TOO_LONG;
		else if ({1'b0, byte_count_d} < need_cnt)             res.status = xfr_pkg::ST_TRUNCATED;
		else if (!sum_matched_d)                              res.status = xfr_pkg::ST_CHECKSUM;
		else if (id_byte_d != cfg.known_msg_id)               res.status = xfr_pkg::ST_UNKNOWN;
		else                                                  res.status = xfr_pkg::ST_OK;
		res.msg_id      = id_byte_d;
		res.arg_byte    = (frame_len_d >= 8'd2) ? second_byte_d : 8'd0;
		res.payload_len = frame_len_d;
	end

	assign res_valid = byte_valid & end_of_burst;

	// Hold burst state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			header_ok_q   <= '0;
			frame_len_q   <= '0;
			running_xor_q <= '0;
			id_byte_q     <= '0;
			second_byte_q <= '0;
			sum_matched_q <= 1'b0;
		end else if (byte_valid) begin
			if (end_of_burst) begin
				byte_count_q  <= '0;
				header_ok_q   <= '0;
				frame_len_q   <= '0;
				running_xor_q <= '0;
				id_byte_q     <= '0;
				second_byte_q <= '0;
				sum_matched_q <= 1'b0;
			end else begin
				byte_count_q  <= byte_count_d;
				header_ok_q   <= header_ok_d;
				frame_len_q   <= frame_len_d;
				running_xor_q <= running_xor_d;
				id_byte_q     <= id_byte_d;
				second_byte_q <= second_byte_d;
				sum_matched_q <= sum_matched_d;
			end
		end
	end

endmodule

>>> hdl/xfr_out_buf.sv
// ----------------------------------------------------------------------------
// xfr_out_buf
// Output register with a skid stage, so a result can wait while new bytes
// keep arriving.
// ----------------------------------------------------------------------------
module xfr_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  xfr_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output xfr_pkg::result_t out_data
);

	logic             out_valid_q;
	logic             skid_valid_q;
	xfr_pkg::result_t out_data_q;
	xfr_pkg::result_t skid_data_q;
	logic             pop;

	assign pop       = out_valid_q & ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Control: drain the skid first, else load or park the new result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q && !pop) skid_valid_q <= 1'b1;
			else out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_data_q <= skid_data_q;
		end else if (push) begin
			if (out_valid_q && !pop) skid_data_q <= push_data;
			else out_data_q <= push_data;
		end
	end

endmodule
